// File: sv/rsa_pkg.sv
// rsa_pkg: shared types and constants for the rgb saturation adjust pipeline
// no dependencies; used by every rsa module and the top level

package rsa_pkg;

	localparam int GAIN_FRAC_BITS_DEF = 12;
	localparam int CH_W = 8;

	localparam logic signed [7:0] PCT_MAX = 8'sd100;
	localparam logic signed [7:0] PCT_MIN = -8'sd100;
	localparam logic [7:0] PCT_FULL = 8'd100;

	typedef struct packed {
		logic [CH_W-1:0] a;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] c;
	} rgb_t;

	typedef struct packed {
		rgb_t ch;
		logic [CH_W:0] s;
		logic gray;
	} pix_t;

endpackage

// File: sv/rsa_gain_sel.sv
// rsa_gain_sel: min/max, lightness sum and gain operand selection (three stages)
// depends on rsa_pkg; feeds the dividend and divisor of rsa_div_pipe

module rsa_gain_sel #(
	parameter int GAIN_FRAC_BITS = rsa_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [rsa_pkg::CH_W-1:0] chan_a,
	input  logic [rsa_pkg::CH_W-1:0] chan_b,
	input  logic [rsa_pkg::CH_W-1:0] chan_c,
	input  logic signed [7:0] pct,
	output logic valid,
	output logic [rsa_pkg::CH_W+GAIN_FRAC_BITS-1:0] dividend,
	output logic [rsa_pkg::CH_W-1:0] divisor,
	output rsa_pkg::pix_t pix
);

	localparam int QW = rsa_pkg::CH_W + GAIN_FRAC_BITS;

	logic valid_s1, valid_s2, valid_s3;
	rsa_pkg::rgb_t ch_s1, ch_s2;
	logic [7:0] mx_s1, mn_s1;
	logic [7:0] mx, mn;
	logic [8:0] s_s2;
	logic [7:0] d_s2, den_s2;
	logic [8:0] s_sum;
	logic [7:0] den;
	logic signed [7:0] pc;
	logic [7:0] k;
	logic [14:0] lhs, rhs;
	logic [7:0] num, dv;
	logic [QW-1:0] dividend_s3;
	logic [7:0] divisor_s3;
	rsa_pkg::pix_t pix_s3;

	// stage 1: largest and smallest channel
	always_comb begin
		mx = chan_a;
		mn = chan_a;
		if (chan_b > mx) mx = chan_b;
		if (chan_b < mn) mn = chan_b;
		if (chan_c > mx) mx = chan_c;
		if (chan_c < mn) mn = chan_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1 <= '{a: chan_a, b: chan_b, c: chan_c};
			mx_s1 <= mx;
			mn_s1 <= mn;
		end
	end

	// stage 2: sum, spread and distance to the nearer end of the range
	assign s_sum = {1'b0, mx_s1} + {1'b0, mn_s1};
	assign den = (s_sum <= 9'd255) ? s_sum[7:0] : 8'(9'd510 - s_sum);

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s2 <= ch_s1;
			s_s2 <= s_sum;
			d_s2 <= mx_s1 - mn_s1;
			den_s2 <= den;
		end
	end

	// stage 3: for p <= 0 use (100+p)/100; else pick the smaller of den/d and 100/(100-p) by cross products
	always_comb begin
		if (pct < rsa_pkg::PCT_MIN) pc = rsa_pkg::PCT_MIN;
		else if (pct > rsa_pkg::PCT_MAX) pc = rsa_pkg::PCT_MAX;
		else pc = pct;
	end

	assign k = rsa_pkg::PCT_FULL - 8'(pc);
	assign lhs = 15'(den_s2) * 15'(k);
	assign rhs = 15'(rsa_pkg::PCT_FULL) * 15'(d_s2);

	always_comb begin
		if (pc <= 8'sd0) begin
			num = rsa_pkg::PCT_FULL + 8'(pc);
			dv = rsa_pkg::PCT_FULL;
		end else if (pc == rsa_pkg::PCT_MAX || lhs <= rhs) begin
			num = den_s2;
			dv = d_s2;
		end else begin
			num = rsa_pkg::PCT_FULL;
			dv = k;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dividend_s3 <= {num, {(GAIN_FRAC_BITS-7){1'b0}}, dv[7:1]};
			divisor_s3 <= dv;
			pix_s3 <= '{ch: ch_s2, s: s_s2, gray: (d_s2 == 8'd0)};
		end
	end

	assign valid = valid_s3;
	assign dividend = dividend_s3;
	assign divisor = divisor_s3;
	assign pix = pix_s3;

endmodule

// File: sv/rsa_div_pipe.sv
// rsa_div_pipe: restoring divider, one quotient bit per pipeline stage
// depends on rsa_pkg; carries the pixel alongside the quotient

module rsa_div_pipe #(
	parameter int GAIN_FRAC_BITS = rsa_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [rsa_pkg::CH_W+GAIN_FRAC_BITS-1:0] dividend,
	input  logic [rsa_pkg::CH_W-1:0] divisor,
	input  rsa_pkg::pix_t in_pix,
	output logic valid,
	output logic [rsa_pkg::CH_W+GAIN_FRAC_BITS-1:0] quotient,
	output rsa_pkg::pix_t pix
);

	localparam int QW = rsa_pkg::CH_W + GAIN_FRAC_BITS;

	logic v_s [QW];
	logic [7:0] rem_s [QW];
	logic [QW-1:0] work_s [QW];
	logic [7:0] div_s [QW];
	rsa_pkg::pix_t pix_s [QW];

	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_stage
			logic v_src;
			logic [7:0] rem_src, div_src;
			logic [QW-1:0] work_src;
			rsa_pkg::pix_t pix_src;
			logic [8:0] t, diff;
			logic ge;

			if (i == 0) begin : g_first
				assign v_src = in_valid;
				assign rem_src = 8'd0;
				assign work_src = dividend;
				assign div_src = divisor;
				assign pix_src = in_pix;
			end else begin : g_next
				assign v_src = v_s[i-1];
				assign rem_src = rem_s[i-1];
				assign work_src = work_s[i-1];
				assign div_src = div_s[i-1];
				assign pix_src = pix_s[i-1];
			end

			assign t = {rem_src, work_src[QW-1]};
			assign diff = t - {1'b0, div_src};
			assign ge = (t >= {1'b0, div_src});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (en) begin
					v_s[i] <= v_src;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? diff[7:0] : t[7:0];
					work_s[i] <= {work_src[QW-2:0], ge};
					div_s[i] <= div_src;
					pix_s[i] <= pix_src;
				end
			end
		end
	endgenerate

	assign valid = v_s[QW-1];
	assign quotient = work_s[QW-1];
	assign pix = pix_s[QW-1];

endmodule

// File: sv/rsa_apply.sv
// rsa_apply: per-channel gain multiply (registered), then round and saturate; gray pixels pass through
// depends on rsa_pkg; takes the gain from rsa_div_pipe

module rsa_apply #(
	parameter int GAIN_FRAC_BITS = rsa_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [rsa_pkg::CH_W+GAIN_FRAC_BITS-1:0] gain,
	input  rsa_pkg::pix_t in_pix,
	output logic valid,
	output rsa_pkg::rgb_t result
);

	localparam int QW = rsa_pkg::CH_W + GAIN_FRAC_BITS;
	localparam int PW = QW + 12;
	localparam int AW = PW + 1;

	logic valid_s1;
	rsa_pkg::pix_t pix_s1;
	logic signed [PW-1:0] prod_a_s1, prod_b_s1, prod_c_s1;
	logic signed [10:0] dx_a, dx_b, dx_c;
	logic signed [QW:0] g_sgn;
	logic signed [AW-1:0] base;

	function automatic logic [7:0] round_sat(input logic signed [PW-1:0] prod,
		input logic signed [AW-1:0] offs);
		logic signed [AW-1:0] acc;
		begin
			acc = AW'(prod) + offs;
			if (acc <= 0) round_sat = 8'd0;
			else if (|acc[AW-2:GAIN_FRAC_BITS+9]) round_sat = 8'd255;
			else round_sat = acc[GAIN_FRAC_BITS+8:GAIN_FRAC_BITS+1];
		end
	endfunction

	assign g_sgn = $signed({1'b0, gain});
	assign dx_a = $signed({2'b0, in_pix.ch.a, 1'b0}) - $signed({2'b0, in_pix.s});
	assign dx_b = $signed({2'b0, in_pix.ch.b, 1'b0}) - $signed({2'b0, in_pix.s});
	assign dx_c = $signed({2'b0, in_pix.ch.c, 1'b0}) - $signed({2'b0, in_pix.s});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= in_pix;
			prod_a_s1 <= PW'(dx_a) * PW'(g_sgn);
			prod_b_s1 <= PW'(dx_b) * PW'(g_sgn);
			prod_c_s1 <= PW'(dx_c) * PW'(g_sgn);
		end
	end

	// (s + 1) << frac: the mid term plus the half-up rounding constant
	assign base = $signed(AW'({1'b0, pix_s1.s} + 10'd1) << GAIN_FRAC_BITS);

	always_comb begin
		if (pix_s1.gray) begin
			result = pix_s1.ch;
		end else begin
			result.a = round_sat(prod_a_s1, base);
			result.b = round_sat(prod_b_s1, base);
			result.c = round_sat(prod_c_s1, base);
		end
	end

	assign valid = valid_s1;

endmodule

// File: sv/rsa_out_skid.sv
// rsa_out_skid: output register plus one skid entry; full flag stalls the pipeline
// depends on rsa_pkg

module rsa_out_skid (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsa_pkg::rgb_t push_pix,
	input  logic out_stall,
	output logic out_valid,
	output rsa_pkg::rgb_t out_pix,
	output logic full
);

	logic out_valid_q, skid_full_q;
	rsa_pkg::rgb_t out_q, skid_q;
	logic take;

	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q <= skid_full_q || push;
			skid_full_q <= 1'b0;
		end else if (push) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_q <= skid_full_q ? skid_q : push_pix;
		end else if (push) begin
			skid_q <= push_pix;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix = out_q;
	assign full = skid_full_q;

endmodule

// File: sv/rgb_saturation_adjust_unit.sv
// rgb_saturation_adjust_unit: HSL-style saturation adjustment of 8-bit RGB pixels
// throughput: one pixel per cycle while in_stall is low; depth is set by the bit-per-stage gain divider
// reset: arst_n clears all valid bits and sets the stored saturation percent (pct_q) to zero
// depends on rsa_pkg, rsa_gain_sel, rsa_div_pipe, rsa_apply, rsa_out_skid

module rgb_saturation_adjust_unit #(
	parameter int GAIN_FRAC_BITS = rsa_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] saturation_percent,
	input  logic in_valid,
	output logic in_stall,
	input  logic [rsa_pkg::CH_W-1:0] chan_a,
	input  logic [rsa_pkg::CH_W-1:0] chan_b,
	input  logic [rsa_pkg::CH_W-1:0] chan_c,
	output logic out_valid,
	input  logic out_stall,
	output logic [rsa_pkg::CH_W-1:0] out_a,
	output logic [rsa_pkg::CH_W-1:0] out_b,
	output logic [rsa_pkg::CH_W-1:0] out_c
);

	localparam int QW = rsa_pkg::CH_W + GAIN_FRAC_BITS;

	logic signed [7:0] pct_q;
	logic en, full;
	logic sel_valid, div_valid, app_valid;
	logic [QW-1:0] dividend, quotient;
	logic [rsa_pkg::CH_W-1:0] divisor;
	rsa_pkg::pix_t sel_pix, div_pix;
	rsa_pkg::rgb_t app_pix, res_pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= 8'sd0;
		end else if (cfg_valid && cfg_ready) begin
			pct_q <= $signed(saturation_percent);
		end
	end

	// whole pipeline advances unless the skid entry is occupied
	assign en = !full;
	assign in_stall = full;

	rsa_gain_sel #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gain_sel (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.chan_a(chan_a),
		.chan_b(chan_b),
		.chan_c(chan_c),
		.pct(pct_q),
		.valid(sel_valid),
		.dividend(dividend),
		.divisor(divisor),
		.pix(sel_pix)
	);

	rsa_div_pipe #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_div_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(sel_valid),
		.dividend(dividend),
		.divisor(divisor),
		.in_pix(sel_pix),
		.valid(div_valid),
		.quotient(quotient),
		.pix(div_pix)
	);

	rsa_apply #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_apply (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(div_valid),
		.gain(quotient),
		.in_pix(div_pix),
		.valid(app_valid),
		.result(app_pix)
	);

	rsa_out_skid u_out_skid (
		.clk(clk),
		.arst_n(arst_n),
		.push(app_valid && en),
		.push_pix(app_pix),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_pix(res_pix),
		.full(full)
	);

	assign out_a = res_pix.a;
	assign out_b = res_pix.b;
	assign out_c = res_pix.c;

endmodule
